// ----- sv/scm_pkg.sv -----
// shared types, constants and helpers for the scalar to rgba colormap
`timescale 1ns / 1ps
package scm_pkg;

	localparam int MAX_ANCHORS = 6;
	localparam int COLOR_TOP   = 255;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 48;
	localparam int NUM_W       = 42;
	localparam int QUO_W       = 8;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANCH_CNT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR_01   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR_23   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR_45   = 3'd5;

	typedef struct packed {
		logic signed [31:0] sample;
		logic               sample_finite;
	} in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} out_t;

	typedef struct packed {
		logic signed [31:0] range_minimum;
		logic signed [31:0] range_maximum;
		logic [2:0]         anchor_count;
		logic [47:0]        anchor_pair_01;
		logic [47:0]        anchor_pair_23;
		logic [47:0]        anchor_pair_45;
	} cfg_t;

	typedef struct packed {
		logic invalid;
		logic sat;
	} flag_t;

	typedef struct packed {
		flag_t            flg;
		logic [NUM_W-1:0] num;
		logic [31:0]      den;
	} div_in_t;

	typedef struct packed {
		flag_t            flg;
		logic [QUO_W-1:0] quo;
	} div_out_t;

	function automatic logic [23:0] anchor_get(cfg_t c, logic [2:0] k);
		logic [23:0] res;
		unique case (k)
			3'd0:    res = c.anchor_pair_01[23:0];
			3'd1:    res = c.anchor_pair_01[47:24];
			3'd2:    res = c.anchor_pair_23[23:0];
			3'd3:    res = c.anchor_pair_23[47:24];
			3'd4:    res = c.anchor_pair_45[23:0];
			3'd5:    res = c.anchor_pair_45[47:24];
			default: res = 24'd0;
		endcase
		return res;
	endfunction

endpackage

// ----- sv/scm_front.sv -----
// range offset, validity checks and rounding numerator for the index divide
`timescale 1ns / 1ps
module scm_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  scm_pkg::in_t     in_data,
	input  scm_pkg::cfg_t    cfg,
	output logic             dn_valid,
	input  logic             dn_stall,
	output scm_pkg::div_in_t dn_data
);
	import scm_pkg::*;

	logic               v_s1, v_s2;
	logic signed [32:0] diff_s1, den_s1;
	logic               inv_s1, neg_s1, sat_s1;
	div_in_t            d_s2;
	logic               rdy1, rdy2;
	logic signed [32:0] diff_c, den_c;

	assign rdy2     = !v_s2 || !dn_stall;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	assign diff_c = 33'(in_data.sample) - 33'(cfg.range_minimum);
	assign den_c  = 33'(cfg.range_maximum) - 33'(cfg.range_minimum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			diff_s1 <= diff_c;
			den_s1  <= den_c;
			inv_s1  <= !in_data.sample_finite || !(cfg.range_maximum > cfg.range_minimum);
			neg_s1  <= diff_c < 0;
			sat_s1  <= diff_c >= den_c;
		end
		if (rdy2 && v_s1) begin
			d_s2.flg.invalid <= inv_s1;
			d_s2.flg.sat     <= sat_s1;
			d_s2.den         <= den_s1[31:0];
			// 2*255*diff + den, divided later by 2*den gives the rounded index
			if (neg_s1 || sat_s1)
				d_s2.num <= '0;
			else
				d_s2.num <= NUM_W'(diff_s1[31:0]) * NUM_W'(2 * COLOR_TOP)
					+ NUM_W'(den_s1[31:0]);
		end
	end

	assign dn_valid = v_s2;
	assign dn_data  = d_s2;
endmodule

// ----- sv/scm_div.sv -----
// one quotient bit per stage restoring divider for the color index
`timescale 1ns / 1ps
module scm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_stall,
	input  scm_pkg::div_in_t  up_data,
	output logic              dn_valid,
	input  logic              dn_stall,
	output scm_pkg::div_out_t dn_data
);
	import scm_pkg::*;

	logic             v_s   [QUO_W];
	logic [NUM_W-1:0] rem_s [QUO_W];
	logic [31:0]      den_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];
	flag_t            flg_s [QUO_W];
	logic             rdy   [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		localparam int BIT = QUO_W - 1 - i;
		logic             pv;
		logic [NUM_W-1:0] prem;
		logic [31:0]      pden;
		logic [QUO_W-1:0] pquo;
		flag_t            pflg;
		logic [NUM_W-1:0] dsh;
		logic [NUM_W:0]   trial;

		if (i == 0) begin : g_first
			assign pv   = up_valid;
			assign prem = up_data.num;
			assign pden = up_data.den;
			assign pquo = '0;
			assign pflg = up_data.flg;
		end else begin : g_next
			assign pv   = v_s[i-1];
			assign prem = rem_s[i-1];
			assign pden = den_s[i-1];
			assign pquo = quo_s[i-1];
			assign pflg = flg_s[i-1];
		end

		if (i == QUO_W - 1) begin : g_last
			assign rdy[i] = !v_s[i] || !dn_stall;
		end else begin : g_mid
			assign rdy[i] = !v_s[i] || rdy[i+1];
		end

		// divisor is twice the range width, aligned to this bit
		assign dsh   = NUM_W'({pden, 1'b0}) << BIT;
		assign trial = {1'b0, prem} - {1'b0, dsh};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i] <= 1'b0;
			else if (rdy[i]) v_s[i] <= pv;
		end

		always_ff @(posedge clk) begin
			if (rdy[i] && pv) begin
				den_s[i] <= pden;
				flg_s[i] <= pflg;
				if (!trial[NUM_W]) begin
					rem_s[i] <= trial[NUM_W-1:0];
					quo_s[i] <= pquo | (QUO_W'(1) << BIT);
				end else begin
					rem_s[i] <= prem;
					quo_s[i] <= pquo;
				end
			end
		end
	end

	assign up_stall    = !rdy[0];
	assign dn_valid    = v_s[QUO_W-1];
	assign dn_data.flg = flg_s[QUO_W-1];
	assign dn_data.quo = quo_s[QUO_W-1];
endmodule

// ----- sv/scm_blend.sv -----
// anchor placement and per channel linear blend with exact rounding
`timescale 1ns / 1ps
module scm_blend (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_stall,
	input  scm_pkg::div_out_t up_data,
	input  scm_pkg::cfg_t     cfg,
	output logic              dn_valid,
	input  logic              dn_stall,
	output scm_pkg::out_t     dn_data
);
	import scm_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        rdy1, rdy2, rdy3, rdy4;
	logic        inv_s1, inv_s2, inv_s3;
	logic [2:0]  left_s1, right_s1;
	logic [7:0]  r_s1;
	logic [16:0] w_s2 [3];
	logic [16:0] w_s3 [3];
	logic [8:0]  q0_s3 [3];
	out_t        out_s4;

	logic [2:0]  n_c, nm1_c, left_c;
	logic [7:0]  idx_c;
	logic [10:0] prod_c, rem_c;
	logic [23:0] a_c, b_c;
	logic [7:0]  ch_c [3];

	assign rdy4     = !v_s4 || !dn_stall;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign up_stall = !rdy1;

	always_comb begin
		if (cfg.anchor_count < 3'd2)
			n_c = 3'd2;
		else if (cfg.anchor_count > 3'(MAX_ANCHORS))
			n_c = 3'(MAX_ANCHORS);
		else
			n_c = cfg.anchor_count;
		nm1_c  = n_c - 3'd1;
		idx_c  = up_data.flg.sat ? 8'(COLOR_TOP) : up_data.quo;
		prod_c = 11'(idx_c) * 11'(nm1_c);
		left_c = 3'(prod_c >= 11'(COLOR_TOP)) + 3'(prod_c >= 11'(2 * COLOR_TOP))
			+ 3'(prod_c >= 11'(3 * COLOR_TOP)) + 3'(prod_c >= 11'(4 * COLOR_TOP))
			+ 3'(prod_c >= 11'(5 * COLOR_TOP));
		rem_c  = prod_c - 11'(left_c) * 11'(COLOR_TOP);
	end

	assign a_c = anchor_get(cfg, left_s1);
	assign b_c = anchor_get(cfg, right_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= up_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && up_valid) begin
			inv_s1   <= up_data.flg.invalid;
			left_s1  <= left_c;
			right_s1 <= (left_c + 3'd1 < nm1_c) ? left_c + 3'd1 : nm1_c;
			r_s1     <= rem_c[7:0];
		end
		if (rdy2 && v_s1) begin
			inv_s2 <= inv_s1;
			for (int c = 0; c < 3; c++) begin
				// left*(255-r) + right*r, doubled plus 255 for round half up
				w_s2[c] <= 17'(({1'b0, 16'(a_c[16-8*c +: 8]) * 16'(8'(COLOR_TOP) - r_s1)
					+ 16'(b_c[16-8*c +: 8]) * 16'(r_s1)}) << 1) + 17'(COLOR_TOP);
			end
		end
		if (rdy3 && v_s2) begin
			inv_s3 <= inv_s2;
			for (int c = 0; c < 3; c++) begin
				w_s3[c]  <= w_s2[c];
				// w*257 >> 17 is w/510 rounded down, at most one short
				q0_s3[c] <= 9'((26'(w_s2[c]) * 26'd257) >> 17);
			end
		end
		if (rdy4 && v_s3) begin
			out_s4.red   <= inv_s3 ? 8'd0 : ch_c[0];
			out_s4.green <= inv_s3 ? 8'd0 : ch_c[1];
			out_s4.blue  <= inv_s3 ? 8'd0 : ch_c[2];
			out_s4.alpha <= inv_s3 ? 8'd0 : 8'(COLOR_TOP);
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			logic [8:0] q;
			q = (19'(w_s3[c]) >= (19'(q0_s3[c]) + 19'd1) * 19'(2 * COLOR_TOP))
				? q0_s3[c] + 9'd1 : q0_s3[c];
			ch_c[c] = q[8] ? 8'd255 : q[7:0];
		end
	end

	assign dn_valid = v_s4;
	assign dn_data  = out_s4;
endmodule

// ----- sv/scalar_to_rgba_colormap.sv -----
// top level of the scalar to rgba colormap pipeline
`timescale 1ns / 1ps
// maps a signed q16.16 sample to an rgba color by linear blending between
// up to six color anchors spread evenly over a 256-level index
// input channel: in_valid / in_stall / in_data, one sample per transaction
// output channel: out_valid / out_stall / out_data, one color per transaction
// config port: cfg_wr_en writes cfg_wdata to register cfg_index at the clock
// edge; indexes past the anchor pairs are ignored; write only while idle
// stages from accept to result: 2 front stages, 8 divider stages that each
// resolve one index bit, then 4 blend stages
// throughput: one transaction per cycle while out_stall is low, set by the fully pipelined divider
// a stalled receiver freezes only the stages that hold data; empty stages
// keep filling, so in_stall rises once every stage holds a transaction
// invalid sample or empty range gives an all-zero color
// reset empties the pipe and loads black to white over one anchor gap
module scalar_to_rgba_colormap (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  scm_pkg::in_t                      in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output scm_pkg::out_t                     out_data,
	input  logic                              cfg_wr_en,
	input  logic [scm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [scm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import scm_pkg::*;

	cfg_t     cfg_q;
	logic     f_valid, f_stall, d_valid, d_stall;
	div_in_t  f_data;
	div_out_t d_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_minimum  <= 32'sd0;
			cfg_q.range_maximum  <= 32'sd65536;
			cfg_q.anchor_count   <= 3'd2;
			cfg_q.anchor_pair_01 <= 48'hFFFFFF000000;
			cfg_q.anchor_pair_23 <= '0;
			cfg_q.anchor_pair_45 <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_RANGE_MIN: cfg_q.range_minimum  <= cfg_wdata[31:0];
				REG_RANGE_MAX: cfg_q.range_maximum  <= cfg_wdata[31:0];
				REG_ANCH_CNT:  cfg_q.anchor_count   <= cfg_wdata[2:0];
				REG_PAIR_01:   cfg_q.anchor_pair_01 <= cfg_wdata;
				REG_PAIR_23:   cfg_q.anchor_pair_23 <= cfg_wdata;
				REG_PAIR_45:   cfg_q.anchor_pair_45 <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// offset, range checks and rounding numerator
	scm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.dn_valid (f_valid),
		.dn_stall (f_stall),
		.dn_data  (f_data)
	);

	// index = rounded offset*255/range, one bit per stage
	scm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (f_valid),
		.up_stall (f_stall),
		.up_data  (f_data),
		.dn_valid (d_valid),
		.dn_stall (d_stall),
		.dn_data  (d_data)
	);

	// anchor lookup and per channel blend
	scm_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (d_valid),
		.up_stall (d_stall),
		.up_data  (d_data),
		.cfg      (cfg_q),
		.dn_valid (out_valid),
		.dn_stall (out_stall),
		.dn_data  (out_data)
	);
endmodule

// ----- tb/scm_checker.sv -----
// checker for the colormap: watches both channels and the config port, predicts colors and compares
`timescale 1ns / 1ps
module scm_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  scm_pkg::in_t                   in_data,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  scm_pkg::out_t                  out_data,
	input  logic                           cfg_wr_en,
	input  logic [scm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                             mismatches,
	output int                             colors_pending
);
	import scm_pkg::*;

	logic signed [31:0] lo_bound, hi_bound;
	logic [2:0]         n_anchors;
	logic [47:0]        pairs [3];
	out_t               color_queue [$];

	assign colors_pending = color_queue.size();

	function automatic logic [23:0] anchor_rgb(int k);
		if (k >= 6)
			return 24'd0;
		return (k % 2) ? pairs[k/2][47:24] : pairs[k/2][23:0];
	endfunction

	// integer-exact mapping of one sample to its color
	function automatic out_t map_color(in_t d);
		out_t        c;
		longint      num, den, idx, prod, left, right, r, al, ar, v, ch;
		int          n;
		logic [23:0] a, b;
		c = '0;
		if (!d.sample_finite || !(hi_bound > lo_bound))
			return c;
		num = (longint'(d.sample) - longint'(lo_bound)) * 255;
		den = longint'(hi_bound) - longint'(lo_bound);
		if (num >= 0)
			idx = (2 * num + den) / (2 * den);
		else
			idx = -((2 * (-num) + den) / (2 * den));
		if (idx < 0) idx = 0;
		if (idx > 255) idx = 255;
		n = n_anchors;
		if (n < 2) n = 2;
		if (n > 6) n = 6;
		prod  = idx * (n - 1);
		left  = prod / 255;
		r     = prod % 255;
		right = (left + 1 < n - 1) ? left + 1 : n - 1;
		a = anchor_rgb(int'(left));
		b = anchor_rgb(int'(right));
		for (int k = 0; k < 3; k++) begin
			al = (a >> (16 - 8 * k)) & 8'hff;
			ar = (b >> (16 - 8 * k)) & 8'hff;
			v  = al * 255 + (ar - al) * r;
			ch = (2 * v + 255) / 510;
			if (ch > 255) ch = 255;
			if (k == 0) c.red = ch[7:0];
			else if (k == 1) c.green = ch[7:0];
			else c.blue = ch[7:0];
		end
		c.alpha = 8'd255;
		return c;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			lo_bound  <= 32'sd0;
			hi_bound  <= 32'sd65536;
			n_anchors <= 3'd2;
			pairs[0]  <= 48'hffffff000000;
			pairs[1]  <= '0;
			pairs[2]  <= '0;
			color_queue.delete();
		end else begin
			// predict with the settings in force before this edge
			if (in_valid && !in_stall)
				color_queue.insert(color_queue.size(), map_color(in_data));
			if (out_valid && !out_stall) begin
				if (color_queue.size() == 0) begin
					$display("mismatch at %0t: color with no sample waiting", $realtime);
					mismatches++;
				end else begin
					want = color_queue.pop_front();
					if (out_data.red !== want.red) report("red", out_data.red, want.red);
					if (out_data.green !== want.green)
						report("green", out_data.green, want.green);
					if (out_data.blue !== want.blue) report("blue", out_data.blue, want.blue);
					if (out_data.alpha !== want.alpha)
						report("alpha", out_data.alpha, want.alpha);
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_RANGE_MIN: lo_bound <= cfg_wdata[31:0];
					REG_RANGE_MAX: hi_bound <= cfg_wdata[31:0];
					REG_ANCH_CNT:  n_anchors <= cfg_wdata[2:0];
					REG_PAIR_01:   pairs[0] <= cfg_wdata;
					REG_PAIR_23:   pairs[1] <= cfg_wdata;
					REG_PAIR_45:   pairs[2] <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- tb/testbench.sv -----
// top of the colormap testbench: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module testbench;
	import scm_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_t                  out_data;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    mismatches;
	int                    colors_pending;

	// current range, mirrored here so random samples land where it matters
	logic signed [31:0] cur_lo, cur_hi;
	int                 burst_left;
	bit                 long_hold;

	scalar_to_rgba_colormap uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	scm_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mismatches     (mismatches),
		.colors_pending (colors_pending)
	);

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#3ms;
		$display("Regression FAIL");
		$finish;
	end

	// receiver: stall pattern switches among four modes, picked at random
	initial begin
		int mode, left_in_mode;
		bit hold_done;
		out_stall    = 1'b0;
		mode         = 0;
		left_in_mode = 0;
		hold_done    = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold && !hold_done) begin
				// long hold-off so the pipe fills and the input stalls
				out_stall <= 1'b1;
				repeat (80) @(posedge clk);
				hold_done = 1'b1;
			end
			if (left_in_mode == 0) begin
				mode         = $urandom_range(0, 3);
				left_in_mode = $urandom_range(50, 300);
			end
			left_in_mode--;
			case (mode)
				0:       out_stall <= 1'b0;
				1:       out_stall <= ($urandom_range(0, 99) < 30);
				2:       out_stall <= ($urandom_range(0, 99) < 70);
				default: out_stall <= (left_in_mode % 4 == 0);
			endcase
		end
	end

	// one sample transaction; valid stays high inside a burst
	task automatic send_sample(logic signed [31:0] s, logic fin);
		int gap;
		in_data  <= '{sample: s, sample_finite: fin};
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// wait for every color to come back, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (colors_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic set_config(logic signed [31:0] lo, logic signed [31:0] hi, logic [2:0] cnt,
			logic [47:0] p01, logic [47:0] p23, logic [47:0] p45);
		write_reg(REG_RANGE_MIN, {16'($urandom), lo});
		write_reg(REG_RANGE_MAX, {16'($urandom), hi});
		write_reg(REG_ANCH_CNT, {45'($urandom), cnt});
		write_reg(REG_PAIR_01, p01);
		write_reg(REG_PAIR_23, p23);
		write_reg(REG_PAIR_45, p45);
		// indexes past the pairs must be ignored
		write_reg(3'd6, {$urandom, 16'($urandom)});
		write_reg(3'd7, {$urandom, 16'($urandom)});
		cfg_wr_en <= 1'b0;
		cur_lo = lo;
		cur_hi = hi;
	endtask

	function automatic logic [47:0] rand_pair();
		return {16'($urandom), $urandom};
	endfunction

	// random sample: mostly inside the range, some near its ends, some anywhere
	function automatic logic signed [31:0] pick_sample();
		longint span, s;
		int     sel;
		sel  = $urandom_range(0, 99);
		span = longint'(cur_hi) - longint'(cur_lo);
		if (span > 0 && sel < 60)
			s = longint'(cur_lo) + ((span * $urandom_range(0, 65535)) >>> 16);
		else if (sel < 80)
			s = (($urandom_range(0, 1) ? longint'(cur_lo) : longint'(cur_hi))
				+ $signed($urandom_range(0, 64)) - 32);
		else
			return $signed($urandom);
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return s[31:0];
	endfunction

	initial begin
		longint mid;
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_wr_en  = 1'b0;
		cfg_index  = '0;
		cfg_wdata  = '0;
		burst_left = 0;
		long_hold  = 1'b0;
		cur_lo     = 32'sd0;
		cur_hi     = 32'sd65536;
		arst_n     = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, field extremes, range ends, rounding halves
		send_sample(32'sh80000000, 1'b1);
		send_sample(32'sh7fffffff, 1'b1);
		send_sample(32'sd0, 1'b1);
		send_sample(32'sd65536, 1'b1);
		send_sample(32'sd32768, 1'b1);
		send_sample(32'sd32896, 1'b1);
		send_sample(32'sd32639, 1'b1);
		send_sample(32'sd129, 1'b1);
		send_sample(32'sd128, 1'b1);
		send_sample(-32'sd129, 1'b1);
		send_sample(32'sd32768, 1'b0);
		send_sample(32'sh7fffffff, 1'b0);
		drain();

		// several settings: full range with six anchors, all-ones and zero anchors
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_config(32'sh80000000, 32'sh7fffffff, 3'd6, 48'hffffff000000,
						48'h00ff00ff0000, 48'hffffff0000ff);
				1: set_config(32'sd0, 32'sd0, 3'd3, rand_pair(), rand_pair(), rand_pair());
				2: set_config(32'sd100, -32'sd100, 3'd4, rand_pair(), rand_pair(), rand_pair());
				3: set_config(-32'sd65536, 32'sd65536, 3'd0, rand_pair(), 48'd0, 48'd0);
				4: set_config(32'sd0, 32'sd255, 3'd7, 48'hffffffffffff, 48'hffffffffffff,
						48'hffffffffffff);
				5: set_config(32'sd5, 32'sd6, 3'd1, rand_pair(), rand_pair(), rand_pair());
				6: set_config(32'sh7ffffffe, 32'sh7fffffff, 3'd5, rand_pair(), rand_pair(),
						rand_pair());
				default: set_config($signed($urandom) >>> $urandom_range(0, 20),
						$signed($urandom) >>> $urandom_range(0, 20),
						3'($urandom_range(2, 6)), rand_pair(), rand_pair(), rand_pair());
			endcase
			if (phase == 0) begin
				send_sample(32'sh80000000, 1'b1);
				send_sample(32'sh7fffffff, 1'b1);
				send_sample(32'sd0, 1'b1);
				send_sample(32'sd0, 1'b0);
			end
			for (int i = 0; i < 172; i++) begin
				// a long receiver hold-off while samples keep coming
				if (phase == 3 && i == 20)
					long_hold = 1'b1;
				send_sample(pick_sample(), $urandom_range(0, 9) != 0);
			end
			drain();
		end

		// random settings mid-range, samples around the midpoint
		repeat (3) begin
			set_config(-32'sd1000, 32'sd1000, 3'($urandom), rand_pair(), rand_pair(),
				rand_pair());
			mid = 0;
			repeat (20) send_sample(mid + $urandom_range(0, 20) - 10, 1'b1);
			drain();
		end

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
sv/scm_pkg.sv
sv/scm_front.sv
sv/scm_div.sv
sv/scm_blend.sv
sv/scalar_to_rgba_colormap.sv
tb/scm_checker.sv
tb/testbench.sv
